/* rtl/core/ptts_pkg.sv */
// Shared types, codes and sizes of the priority task table scheduler.
package ptts_pkg;

  localparam int PTTS_TABLE_DEPTH = 16;

  typedef enum logic [2:0] {
    ACT_ADD        = 3'd0,
    ACT_DELETE     = 3'd1,
    ACT_UPDATE     = 3'd2,
    ACT_SET_STATUS = 3'd3,
    ACT_READ       = 3'd4,
    ACT_TAKE       = 3'd5
  } action_t;

  localparam logic [1:0] ST_PENDING     = 2'd0;
  localparam logic [1:0] ST_IN_PROGRESS = 2'd1;

  typedef struct packed {
    logic [15:0] id;
    logic [1:0]  prio;
    logic [1:0]  status;
    logic [31:0] due;
  } entry_t;

  localparam int PTTS_ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_COMMIT
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_last;
  } ctl_sts_t;

endpackage

/* rtl/core/ptts_ram.sv */
// Generic single-port-write, registered-read RAM.
module ptts_ram #(
  parameter int WIDTH = ptts_pkg::PTTS_ENTRY_W,
  parameter int DEPTH = ptts_pkg::PTTS_TABLE_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/ptts_ctrl.sv */
// Sequencer of the task table scheduler: load, table scan, commit.
module ptts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output ptts_pkg::ctl_cmd_t  cmd,
  input  ptts_pkg::ctl_sts_t  sts
);
  import ptts_pkg::*;

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

/* rtl/core/ptts_dpath.sv */
// Datapath of the task table scheduler: table store, scan evaluation, commit.
module ptts_dpath #(
  parameter int TABLE_DEPTH = ptts_pkg::PTTS_TABLE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ptts_pkg::ctl_cmd_t  cmd,
  output ptts_pkg::ctl_sts_t  sts,
  input  logic [2:0]          in_action,
  input  logic [15:0]         in_task_id,
  input  logic [1:0]          in_task_priority,
  input  logic [31:0]         in_task_due,
  input  logic [1:0]          in_new_status,
  output logic                out_valid,
  output logic                out_ok,
  output logic [15:0]         out_entry_id,
  output logic [1:0]          out_entry_priority,
  output logic [31:0]         out_entry_due,
  output logic [1:0]          out_entry_status
);
  import ptts_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  // Latched command beat.
  action_t     act_r;
  logic [15:0] id_r;
  logic [1:0]  prio_r;
  logic [31:0] due_r;
  logic [1:0]  nstat_r;

  // Scan state.
  logic [AW-1:0] addr_r;
  logic          rd_vld_r;
  logic [AW-1:0] rd_idx_r;
  logic          found_r;
  logic [AW-1:0] slot_r;
  entry_t        best_r;

  logic [TABLE_DEPTH-1:0] valid_r;
  logic [15:0]            next_id_r;

  logic        out_valid_r;
  logic        out_ok_r;
  entry_t      out_entry_r;

  logic [PTTS_ENTRY_W-1:0] rdata;
  entry_t cand;
  logic   cand_valid;
  logic   hit;
  logic   commit_ok;
  logic   commit_wr;
  entry_t commit_entry;

  // True when entry a ranks ahead of entry b for take-next.
  function automatic logic ranks_before(entry_t a, entry_t b);
    logic r;
    if (a.prio != b.prio) begin
      r = (a.prio > b.prio);
    end else if (a.due != b.due) begin
      r = (a.due < b.due);
    end else begin
      r = (a.id < b.id);
    end
    return r;
  endfunction

  ptts_ram #(
    .WIDTH(PTTS_ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (commit_wr),
    .waddr (slot_r),
    .wdata (commit_entry),
    .re    (cmd.scan),
    .raddr (addr_r),
    .rdata (rdata)
  );

  assign sts.scan_last = (addr_r == AW'(TABLE_DEPTH - 1));

  assign cand       = entry_t'(rdata);
  assign cand_valid = valid_r[rd_idx_r];

  // Evaluate the slot whose data came back from the table this cycle.
  always_comb begin
    hit = 1'b0;
    case (act_r)
      ACT_ADD: begin
        hit = rd_vld_r && !found_r && !cand_valid;
      end
      ACT_DELETE, ACT_UPDATE, ACT_SET_STATUS, ACT_READ: begin
        hit = rd_vld_r && !found_r && cand_valid && (cand.id == id_r);
      end
      ACT_TAKE: begin
        hit = rd_vld_r && cand_valid && (cand.status == ST_PENDING) &&
              (!found_r || ranks_before(cand, best_r));
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  // Entry as it stands after the action, and whether it goes back to the table.
  always_comb begin
    commit_ok    = 1'b0;
    commit_wr    = 1'b0;
    commit_entry = best_r;
    case (act_r)
      ACT_ADD: begin
        commit_ok           = found_r && (next_id_r != 16'd0);
        commit_entry.id     = next_id_r;
        commit_entry.prio   = prio_r;
        commit_entry.status = ST_PENDING;
        commit_entry.due    = due_r;
        commit_wr           = cmd.commit && commit_ok;
      end
      ACT_DELETE, ACT_READ: begin
        commit_ok = found_r;
      end
      ACT_UPDATE: begin
        commit_ok         = found_r;
        commit_entry.prio = prio_r;
        commit_entry.due  = due_r;
        commit_wr         = cmd.commit && found_r;
      end
      ACT_SET_STATUS: begin
        commit_ok           = found_r;
        commit_entry.status = nstat_r;
        commit_wr           = cmd.commit && found_r;
      end
      ACT_TAKE: begin
        commit_ok           = found_r;
        commit_entry.status = ST_IN_PROGRESS;
        commit_wr           = cmd.commit && found_r;
      end
      default: begin
        commit_ok = 1'b0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      next_id_r   <= 16'd1;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      rd_vld_r    <= cmd.scan;
      out_valid_r <= cmd.commit;
      if (cmd.load) begin
        found_r <= 1'b0;
      end else if (hit) begin
        found_r <= 1'b1;
      end
      if (cmd.commit && commit_ok) begin
        if (act_r == ACT_ADD) begin
          valid_r[slot_r] <= 1'b1;
          next_id_r       <= next_id_r + 16'd1;
        end else if (act_r == ACT_DELETE) begin
          valid_r[slot_r] <= 1'b0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= action_t'(in_action);
      id_r    <= in_task_id;
      prio_r  <= in_task_priority;
      due_r   <= in_task_due;
      nstat_r <= in_new_status;
      addr_r  <= '0;
    end else if (cmd.scan) begin
      addr_r <= addr_r + AW'(1);
    end
    if (cmd.scan) begin
      rd_idx_r <= addr_r;
    end
    if (hit) begin
      slot_r <= rd_idx_r;
      best_r <= cand;
    end
    if (cmd.commit) begin
      out_ok_r    <= commit_ok;
      out_entry_r <= commit_ok ? commit_entry : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_ok             = out_ok_r;
  assign out_entry_id       = out_entry_r.id;
  assign out_entry_priority = out_entry_r.prio;
  assign out_entry_due      = out_entry_r.due;
  assign out_entry_status   = out_entry_r.status;

endmodule

/* rtl/core/priority_task_table_scheduler_unit.sv */
// Top level of the priority task table scheduler.
// The result beat follows the load, the scan of every slot, the S_LAST state and the commit.
// A new command beat is taken only once the current one is through and busy is low;
// the pace is set by the walk over the table RAM, one slot per cycle through its single read port.
// Reset (rst_n low, synchronous) empties the table and sets the next id to one.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
module priority_task_table_scheduler_unit #(
  parameter int TABLE_DEPTH = ptts_pkg::PTTS_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_action,
  input  logic [15:0] in_task_id,
  input  logic [1:0]  in_task_priority,
  input  logic [31:0] in_task_due,
  input  logic [1:0]  in_new_status,
  output logic        out_valid,
  output logic        out_ok,
  output logic [15:0] out_entry_id,
  output logic [1:0]  out_entry_priority,
  output logic [31:0] out_entry_due,
  output logic [1:0]  out_entry_status
);
  import ptts_pkg::*;

  // The controller owns sequencing only; every table access, the ranking
  // compare and the result registers live in the datapath.
  ctl_cmd_t cmd;
  ctl_sts_t sts;

  ptts_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  // Each command walks every slot: add looks for the lowest free slot,
  // the id lookups take the first valid match, and take-next keeps the best
  // pending entry seen so far. At commit, add, update, set-status and take write the slot back.
  ptts_dpath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_action          (in_action),
    .in_task_id         (in_task_id),
    .in_task_priority   (in_task_priority),
    .in_task_due        (in_task_due),
    .in_new_status      (in_new_status),
    .out_valid          (out_valid),
    .out_ok             (out_ok),
    .out_entry_id       (out_entry_id),
    .out_entry_priority (out_entry_priority),
    .out_entry_due      (out_entry_due),
    .out_entry_status   (out_entry_status)
  );

  // A taken command beat always makes the block busy on the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command beat taken but block not busy");

  // Leaving busy after a normal run always delivers exactly the result beat.
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("command finished without a result beat");

  // A failed action reports an all-zero entry.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_entry_id == 16'd0 && out_entry_due == 32'd0 &&
                                out_entry_priority == 2'd0 && out_entry_status == 2'd0))
    else $error("failed result carries entry data");

  // Id zero is never handed out, so a successful beat never shows it.
  a_ok_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ok) |-> (out_entry_id != 16'd0))
    else $error("successful result with id zero");

  // A result beat never overlaps a running command.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy || $past(start))
    else $error("result beat while a command is still running");

endmodule
